FILE: sv/thrm_pkg.sv
// Shared widths, calibration data and ROM lookup for the thermistor interpolator.
package thrm_pkg;

    localparam int ADC_W            = 10;
    localparam int TEMP_W           = 11;
    localparam int ENTRY_W          = ADC_W + TEMP_W;
    localparam int DY_W             = TEMP_W + 1;
    localparam int PROD1_W          = 2 * TEMP_W;
    localparam int PROD2_W          = DY_W + ADC_W + 1;
    localparam int NUM_W            = PROD2_W + 1;
    localparam int DATA_POINTS      = 50;
    localparam int TABLE_POINTS_DEF = 50;
    localparam int ROM_IDX_W        = 8;

    localparam logic [ADC_W-1:0] BASE_ADC [DATA_POINTS] = '{
        10'd1,   10'd31,  10'd41,  10'd51,  10'd61,  10'd71,  10'd81,  10'd91,
        10'd101, 10'd111, 10'd121, 10'd131, 10'd141, 10'd151, 10'd161, 10'd171,
        10'd181, 10'd191, 10'd201, 10'd221, 10'd241, 10'd261, 10'd281, 10'd301,
        10'd331, 10'd361, 10'd391, 10'd421, 10'd451, 10'd491, 10'd531, 10'd571,
        10'd611, 10'd641, 10'd681, 10'd711, 10'd751, 10'd791, 10'd811, 10'd831,
        10'd871, 10'd881, 10'd901, 10'd921, 10'd941, 10'd971, 10'd981, 10'd991,
        10'd1001, 10'd1021
    };

    localparam logic signed [TEMP_W-1:0] BASE_TEMP [DATA_POINTS] = '{
        11'sd938, 11'sd314, 11'sd290, 11'sd272, 11'sd258, 11'sd247, 11'sd237,
        11'sd229, 11'sd221, 11'sd215, 11'sd209, 11'sd204, 11'sd199, 11'sd195,
        11'sd190, 11'sd187, 11'sd183, 11'sd179, 11'sd176, 11'sd170, 11'sd165,
        11'sd160, 11'sd155, 11'sd150, 11'sd144, 11'sd139, 11'sd133, 11'sd128,
        11'sd123, 11'sd117, 11'sd111, 11'sd105, 11'sd100, 11'sd95,  11'sd90,
        11'sd85,  11'sd79,  11'sd72,  11'sd69,  11'sd65,  11'sd57,  11'sd55,
        11'sd51,  11'sd45,  11'sd39,  11'sd28,  11'sd23,  11'sd17,  11'sd9,
        -11'sd27
    };

    // Entries past the data repeat the last calibration point.
    function automatic logic [ENTRY_W-1:0] rom_entry(input logic [ROM_IDX_W-1:0] idx);
        int k;
        k = (int'(idx) < DATA_POINTS) ? int'(idx) : DATA_POINTS - 1;
        return {BASE_ADC[k], BASE_TEMP[k]};
    endfunction

endpackage

FILE: sv/thrm_if.sv
// Valid/ready channel interfaces for ADC samples and temperature results.
interface thrm_sample_if;
    import thrm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADC_W-1:0]  adc_value;

    modport source (output valid, output adc_value, input ready);
    modport sink   (input valid, input adc_value, output ready);
endinterface

interface thrm_result_if;
    import thrm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature;
    logic                      out_of_range;

    modport source (output valid, output temperature, output out_of_range, input ready);
    modport sink   (input valid, input temperature, input out_of_range, output ready);
endinterface

FILE: sv/thrm_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
module thrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [thrm_pkg::NUM_W-1:0]  dividend,
    input  logic [thrm_pkg::ADC_W-1:0]  divisor,
    output logic                        done,
    output logic [thrm_pkg::NUM_W-1:0]  quotient
);
    import thrm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ADC_W-1:0] rem_reg;
    logic [ADC_W-1:0] dvs_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [ADC_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? ADC_W'(shifted - {1'b0, dvs_reg}) : shifted[ADC_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/thermistor_table_interpolator_top.sv
// Thermistor table interpolator: ROM scan, linear interpolation, iterative divide.
// Steps: an accepted sample scans the ROM one entry per cycle up to the first breakpoint
//   at or above the sample (or the last entry); an exact match or clamp then goes to emit,
//   while an interpolated sample passes through multiply, add and the bit-serial divider.
// One sample at a time: a new sample is accepted only once the block is back in idle.
// Reset: rst_n clears control and the output valid; the ROM needs no loading.
module thermistor_table_interpolator_top #(
    parameter int TABLE_POINTS = thrm_pkg::TABLE_POINTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    thrm_sample_if.sink     sample,
    thrm_result_if.source   result
);
    import thrm_pkg::*;

    localparam int IDX_W = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_ADD  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADC_W-1:0]           adc_reg;
    logic [IDX_W-1:0]           addr_reg;
    logic [ENTRY_W-1:0]         rom_q_reg;
    logic [IDX_W-1:0]           q_idx_reg;
    logic                       q_valid_reg;
    logic [ENTRY_W-1:0]         prev_reg;
    logic [ADC_W-1:0]           den_reg;
    logic [ADC_W-1:0]           dx_reg;
    logic signed [DY_W-1:0]     dy_reg;
    logic signed [TEMP_W-1:0]   y1_reg;
    logic signed [PROD1_W-1:0]  prod1_reg;
    logic signed [PROD2_W-1:0]  prod2_reg;
    logic                       neg_reg;
    logic signed [TEMP_W-1:0]   res_temp_reg;
    logic                       res_flag_reg;
    logic                       out_valid_reg;
    logic signed [TEMP_W-1:0]   out_temp_reg;
    logic                       out_flag_reg;

    logic [ADC_W-1:0]           x_q;
    logic signed [TEMP_W-1:0]   y_q;
    logic [ADC_W-1:0]           x_prev;
    logic signed [TEMP_W-1:0]   y_prev;
    logic                       hit;
    logic                       past_end;
    logic                       accept;
    logic                       out_free;
    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           mag;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           quotient;
    logic [TEMP_W-1:0]          quo_low;

    assign x_q      = rom_q_reg[ENTRY_W-1:TEMP_W];
    assign y_q      = signed'(rom_q_reg[TEMP_W-1:0]);
    assign x_prev   = prev_reg[ENTRY_W-1:TEMP_W];
    assign y_prev   = signed'(prev_reg[TEMP_W-1:0]);
    assign hit      = q_valid_reg && (x_q >= adc_reg);
    assign past_end = q_valid_reg && (q_idx_reg == LAST_IDX);
    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign num      = NUM_W'(prod1_reg) + NUM_W'(prod2_reg);
    assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign div_start = (state_reg == ST_ADD);
    assign quo_low  = quotient[TEMP_W-1:0];

    assign sample.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = (x_q == adc_reg || q_idx_reg == '0) ? ST_EMIT : ST_MUL;
                else if (past_end)
                    state_next = ST_EMIT;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                q_valid_reg <= 1'b0;
            else if (state_reg == ST_SCAN)
                q_valid_reg <= 1'b1;
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Synchronous ROM port: one entry per cycle while scanning, data registered from the address.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            rom_q_reg <= rom_entry(ROM_IDX_W'(addr_reg));
            q_idx_reg <= addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            adc_reg  <= sample.adc_value;
            addr_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (addr_reg != LAST_IDX)
                addr_reg <= addr_reg + 1'b1;
            if (hit)
            begin
                den_reg      <= x_q - x_prev;
                dx_reg       <= adc_reg - x_prev;
                dy_reg       <= DY_W'(y_q) - DY_W'(y_prev);
                y1_reg       <= y_prev;
                res_temp_reg <= y_q;
                // Below the first breakpoint clamps; an exact match does not.
                res_flag_reg <= (x_q != adc_reg) && (q_idx_reg == '0);
            end
            else if (past_end)
            begin
                res_temp_reg <= y_q;
                res_flag_reg <= 1'b1;
            end
            else if (q_valid_reg)
                prev_reg <= rom_q_reg;
        end

        if (state_reg == ST_MUL)
        begin
            prod1_reg <= PROD1_W'(y1_reg * signed'({1'b0, den_reg}));
            prod2_reg <= PROD2_W'(dy_reg * signed'({1'b0, dx_reg}));
        end

        if (state_reg == ST_ADD)
            neg_reg <= num[NUM_W-1];

        // Truncate toward zero: divide the magnitude, then restore the sign.
        if (state_reg == ST_DIV && div_done)
        begin
            res_temp_reg <= neg_reg ? signed'(TEMP_W'(-quo_low)) : signed'(quo_low);
            res_flag_reg <= 1'b0;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            out_temp_reg <= res_temp_reg;
            out_flag_reg <= res_flag_reg;
        end
    end

    thrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign result.valid        = out_valid_reg;
    assign result.temperature  = out_temp_reg;
    assign result.out_of_range = out_flag_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && !q_valid_reg)
        else $error("accepted sample did not start a fresh scan");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_valid_reg && !result.ready |=> (state_reg == ST_EMIT))
        else $error("result left the emit state while the output beat was stalled");

    a_scan_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && q_valid_reg |-> (q_idx_reg <= LAST_IDX))
        else $error("scan index ran past the table");

endmodule

FILE: tb/thrm_temperature_checker.sv
// Watches the sample and result channels, predicts each temperature and compares.
module thrm_temperature_checker
    import thrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    thrm_sample_if   sample,
    thrm_result_if   result,
    output int       fail_count,
    output int       temps_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAL_POINTS = 50;

    // Calibration breakpoints: ascending ADC codes and the matching temperatures.
    localparam int CAL_ADC [CAL_POINTS] = '{
        1, 31, 41, 51, 61, 71, 81, 91, 101, 111,
        121, 131, 141, 151, 161, 171, 181, 191, 201, 221,
        241, 261, 281, 301, 331, 361, 391, 421, 451, 491,
        531, 571, 611, 641, 681, 711, 751, 791, 811, 831,
        871, 881, 901, 921, 941, 971, 981, 991, 1001, 1021
    };

    localparam int CAL_TEMP [CAL_POINTS] = '{
        938, 314, 290, 272, 258, 247, 237, 229, 221, 215,
        209, 204, 199, 195, 190, 187, 183, 179, 176, 170,
        165, 160, 155, 150, 144, 139, 133, 128, 123, 117,
        111, 105, 100, 95, 90, 85, 79, 72, 69, 65,
        57, 55, 51, 45, 39, 28, 23, 17, 9, -27
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     out_of_range;
    } temp_reading_t;

    temp_reading_t expected_temps [$];

    initial fail_count = 0;
    initial temps_pending = 0;

    function automatic temp_reading_t predict_temperature(input logic [ADC_W-1:0] adc);
        temp_reading_t r;
        int a;
        int x1;
        int x2;
        int y1;
        int y2;
        int den;
        int num;
        a = int'(adc);
        r.temperature = '0;
        r.out_of_range = 1'b0;
        if (a < CAL_ADC[0])
        begin
            r.temperature = TEMP_W'(CAL_TEMP[0]);
            r.out_of_range = 1'b1;
        end
        else if (a > CAL_ADC[CAL_POINTS-1])
        begin
            r.temperature = TEMP_W'(CAL_TEMP[CAL_POINTS-1]);
            r.out_of_range = 1'b1;
        end
        else
        begin
            for (int i = 0; i < CAL_POINTS; i++)
            begin
                x2 = CAL_ADC[i];
                if (x2 == a)
                begin
                    r.temperature = TEMP_W'(CAL_TEMP[i]);
                    break;
                end
                if (x2 > a)
                begin
                    // first breakpoint above the sample; bracket with the one below
                    x1 = CAL_ADC[i-1];
                    y1 = CAL_TEMP[i-1];
                    y2 = CAL_TEMP[i];
                    den = x2 - x1;
                    num = y1 * den + (a - x1) * (y2 - y1);
                    // integer divide truncates toward zero
                    r.temperature = (den <= 0) ? TEMP_W'(y1) : TEMP_W'(num / den);
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        temp_reading_t want;
        if (!rst_n)
        begin
            expected_temps.delete();
            temps_pending = 0;
        end
        else
        begin
            // retire the result beat before queuing a new sample beat
            if (result.valid && result.ready)
            begin
                if (expected_temps.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected result temperature=%0d out_of_range=%0b",
                             $realtime, result.temperature, result.out_of_range);
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (result.temperature !== want.temperature)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: temperature mismatch: expected %0d, actual %0d",
                                 $realtime, want.temperature, result.temperature);
                    end
                    if (result.out_of_range !== want.out_of_range)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                                 $realtime, want.out_of_range, result.out_of_range);
                    end
                end
            end
            if (sample.valid && sample.ready)
                expected_temps.push_back(predict_temperature(sample.adc_value));
            temps_pending = expected_temps.size();
        end
    end

endmodule

FILE: tb/tb_thermistor_table_interpolator_top.sv
// Top of the interpolator testbench: clock, reset, sample and result traffic, verdict.
module tb_thermistor_table_interpolator_top;
    import thrm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_LOAD = 250;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 200;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   rx_hold_left;
    bit   rx_hold_go;
    int   cycle_count;
    int   fail_count;
    int   temps_pending;

    thrm_sample_if sample ();
    thrm_result_if result ();

    thermistor_table_interpolator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result)
    );

    thrm_temperature_checker temp_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample),
        .result        (result),
        .fail_count    (fail_count),
        .temps_pending (temps_pending)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $realtime, cycle_count, temps_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            result.ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (rx_hold_go)
        begin
            rx_hold_go = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Call at a falling edge; returns at the falling edge after the beat.
    task automatic send_sample(input logic [ADC_W-1:0] code);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample.valid <= 1'b0;
            sample.adc_value <= ADC_W'($urandom);
            @(negedge clk);
        end
        sample.valid <= 1'b1;
        sample.adc_value <= code;
        do
            @(posedge clk);
        while (!sample.ready);
        @(negedge clk);
    endtask

    // Breakpoints and their neighbors, some table edges, the rest (the majority) uniform.
    function automatic logic [ADC_W-1:0] pick_sample();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            v = int'(BASE_ADC[$urandom_range(0, DATA_POINTS-1)]) + $urandom_range(0, 2) - 1;
        else if (roll < 40)
            v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(1018, 1023);
        else
            v = $urandom_range(0, 1023);
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return ADC_W'(v);
    endfunction

    task automatic wait_drained();
        while (temps_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int directed_codes [$];
        directed_codes = '{0, 1, 2, 16, 30, 31, 150, 341, 511, 512, 682, 961,
                           1000, 1001, 1005, 1006, 1007, 1010, 1020, 1021,
                           1022, 1023, 1019};
        cycle_count = 0;
        rx_hold_left = 0;
        rx_hold_go = 1'b0;
        tx_idle_pct = 11;
        rx_idle_pct = 67;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.adc_value = '0;
        result.ready = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // clamps at both ends, exact matches, first and last segment, negative truncation
        foreach (directed_codes[i])
            send_sample(ADC_W'(directed_codes[i]));

        for (int i = 0; i < ITEMS_PER_LOAD; i++)
            send_sample(pick_sample());
        sample.valid <= 1'b0;
        wait_drained();

        tx_idle_pct = 67;
        rx_idle_pct = 11;
        for (int i = 0; i < ITEMS_PER_LOAD; i++)
            send_sample(pick_sample());
        sample.valid <= 1'b0;
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < ITEMS_PER_LOAD; i++)
        begin
            // hold the result side off while samples keep coming
            if (i == 80)
                rx_hold_go = 1'b1;
            // pause the sample side until the block is empty
            if (i == 170)
            begin
                sample.valid <= 1'b0;
                wait_drained();
            end
            send_sample(pick_sample());
        end
        sample.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
